### rtl/core/rlf_graph_coloring_macros.svh
// Assertion macros for the graph coloring block.
`ifndef RLF_GRAPH_COLORING_MACROS_SVH
`define RLF_GRAPH_COLORING_MACROS_SVH
`define RLF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RLF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### rtl/core/rlf_pkg.sv
// Package: types, constants and commands of the graph coloring block.
package rlf_pkg;
   localparam int MAX_VERTICES_DEF = 64;
   localparam int IDX_W = 6;
   localparam int ROW_W = 64;
   localparam int CNT_W = 7;

   typedef struct packed {
      logic [IDX_W-1:0] row_index;
      logic [ROW_W-1:0] row_bits;
      logic             last_row;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] vertex;
      logic [CNT_W-1:0] color;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic init;
      logic rewind;
      logic deg_step;
      logic seed_step;
      logic seed_take;
      logic refresh_step;
      logic score_step;
      logic pick_take;
      logic emit_step;
   } cmd_type;

   typedef struct packed {
      logic scan_end;
      logic any_uncolored;
      logic any_candidate;
      logic emit_end;
   } sts_type;
endpackage

### rtl/core/rlf_ram.sv
// Generic RAM with one write port and one registered read port.
module rlf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### rtl/core/rlf_datapath.sv
// Datapath: adjacency, degree and color memories, masks and the scoring scan.
module rlf_datapath #(
   parameter int MAX_VERTICES = rlf_pkg::MAX_VERTICES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rlf_pkg::req_type          req_data,
   input  logic [rlf_pkg::CNT_W-1:0] vertex_count,
   input  rlf_pkg::cmd_type          cmd,
   output rlf_pkg::sts_type          sts,
   output rlf_pkg::rsp_type          rsp_data
);
   import rlf_pkg::*;
   localparam int AW = $clog2(MAX_VERTICES);

   logic [ROW_W-1:0]        adj_rd;
   logic [CNT_W-1:0]        deg_rd, col_rd;
   logic [AW-1:0]           rd_addr;
   logic [AW:0]             ptr_ff, ptr_in;
   logic [AW:0]             n_ff;
   logic [AW-1:0]           scan_idx;
   logic [MAX_VERTICES-1:0] vmask, unc_ff, cls_ff, reach_ff, cand;
   logic [CNT_W-1:0]        cur_ff;
   logic [AW-1:0]           best_ff;
   logic                    best_v_ff;
   logic [CNT_W-1:0]        bestdeg_ff, maxc_ff, maxd_ff;
   logic [AW-1:0]           pickc_ff, pickd_ff, first_ff;
   logic                    pc_v_ff, pd_v_ff, f_v_ff;
   logic [CNT_W-1:0]        cntc, cntd, cntv;
   logic [MAX_VERTICES-1:0] row_m;
   logic [AW-1:0]           pick;
   logic                    adj_we, col_we;
   logic [AW-1:0]           col_addr;
   logic [CNT_W-1:0]        col_wdata;

   assign adj_we   = cmd.load && ({1'b0, req_data.row_index} < (IDX_W+1)'(MAX_VERTICES));
   assign rd_addr  = ptr_in[AW-1:0];
   assign scan_idx = ptr_ff[AW-1:0];
   assign col_we   = cmd.seed_take || cmd.pick_take;
   assign col_addr = cmd.seed_take ? best_ff : pick;
   assign col_wdata = cmd.seed_take ? cur_ff + 1'b1 : cur_ff;

   rlf_ram #(.WIDTH(ROW_W), .DEPTH(MAX_VERTICES)) u_adj (
      .clock  (clock),
      .wr_en  (adj_we),
      .wr_addr(req_data.row_index[AW-1:0]),
      .wr_data(req_data.row_bits),
      .rd_addr(rd_addr),
      .rd_data(adj_rd)
   );

   rlf_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_deg (
      .clock  (clock),
      .wr_en  (cmd.deg_step),
      .wr_addr(scan_idx),
      .wr_data(cntv),
      .rd_addr(rd_addr),
      .rd_data(deg_rd)
   );

   rlf_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_col (
      .clock  (clock),
      .wr_en  (col_we),
      .wr_addr(col_addr),
      .wr_data(col_wdata),
      .rd_addr(rd_addr),
      .rd_data(col_rd)
   );

   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) vmask[i] = (AW+1)'(i) < n_ff;
   end

   assign row_m = adj_rd[MAX_VERTICES-1:0] & vmask;
   assign cand  = unc_ff & ~reach_ff;
   assign cntv  = CNT_W'($countones(row_m));
   assign cntc  = CNT_W'($countones(row_m & reach_ff & unc_ff));
   assign cntd  = CNT_W'($countones(row_m & unc_ff));
   assign pick  = pc_v_ff ? pickc_ff : (pd_v_ff ? pickd_ff : first_ff);

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.init || cmd.rewind || cmd.seed_take || cmd.pick_take) ptr_in = '0;
      else if (cmd.deg_step || cmd.seed_step || cmd.refresh_step || cmd.score_step ||
               cmd.emit_step)
         ptr_in = ptr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         n_ff <= (AW+1)'(MAX_VERTICES);
         unc_ff <= '0;
         cls_ff <= '0;
         reach_ff <= '0;
         cur_ff <= '0;
         best_ff <= '0;
         best_v_ff <= 1'b0;
         bestdeg_ff <= '0;
         maxc_ff <= '0;
         maxd_ff <= '0;
         pickc_ff <= '0;
         pickd_ff <= '0;
         first_ff <= '0;
         pc_v_ff <= 1'b0;
         pd_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
      end else begin
         ptr_ff <= ptr_in;
         if (cmd.init) begin
            if (vertex_count == '0) n_ff <= (AW+1)'(1);
            else if (vertex_count > CNT_W'(MAX_VERTICES)) n_ff <= (AW+1)'(MAX_VERTICES);
            else n_ff <= vertex_count[AW:0];
            cur_ff <= '0;
         end
         if (cmd.deg_step && ptr_ff == '0) unc_ff <= vmask;
         if (cmd.rewind) begin
            best_v_ff <= 1'b0;
            bestdeg_ff <= '0;
            maxc_ff <= '0;
            maxd_ff <= '0;
            pc_v_ff <= 1'b0;
            pd_v_ff <= 1'b0;
            f_v_ff <= 1'b0;
         end
         if (cmd.seed_step && unc_ff[scan_idx] && (!best_v_ff || deg_rd > bestdeg_ff)) begin
            best_ff <= scan_idx;
            best_v_ff <= 1'b1;
            bestdeg_ff <= deg_rd;
         end
         if (cmd.refresh_step && cls_ff[scan_idx]) reach_ff <= reach_ff | row_m;
         if (cmd.score_step && cand[scan_idx]) begin
            if (!f_v_ff) begin
               first_ff <= scan_idx;
               f_v_ff <= 1'b1;
            end
            if (cntc > maxc_ff) begin
               maxc_ff <= cntc;
               pickc_ff <= scan_idx;
               pc_v_ff <= 1'b1;
            end
            if (cntd > maxd_ff) begin
               maxd_ff <= cntd;
               pickd_ff <= scan_idx;
               pd_v_ff <= 1'b1;
            end
         end
         if (cmd.seed_take) begin
            cur_ff <= cur_ff + 1'b1;
            unc_ff[best_ff] <= 1'b0;
            cls_ff <= MAX_VERTICES'(1) << best_ff;
            reach_ff <= '0;
         end
         if (cmd.pick_take) begin
            unc_ff[pick] <= 1'b0;
            cls_ff[pick] <= 1'b1;
            reach_ff <= '0;
         end
      end
   end

   assign sts.scan_end      = ptr_ff == n_ff;
   assign sts.any_uncolored = unc_ff != '0;
   assign sts.any_candidate = cand != '0;
   assign sts.emit_end      = (ptr_ff + 1'b1) == n_ff;

   assign rsp_data.vertex = IDX_W'(scan_idx);
   assign rsp_data.color  = col_rd;
   assign rsp_data.last   = sts.emit_end;
endmodule

### rtl/core/rlf_control.sv
// Controller: sequences loading, degree pass, seeding, refresh, scoring and output.
module rlf_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_last,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  rlf_pkg::sts_type sts,
   output rlf_pkg::cmd_type cmd
);
   import rlf_pkg::*;
   `include "rlf_graph_coloring_macros.svh"

   typedef enum logic [7:0] {
      S_LOAD    = 8'b00000001,
      S_INIT    = 8'b00000010,
      S_DEG     = 8'b00000100,
      S_SEED    = 8'b00001000,
      S_REFRESH = 8'b00010000,
      S_SCORE   = 8'b00100000,
      S_EMIT    = 8'b01000000,
      S_CHECK   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic      pend_seed_ff, pend_seed_in;

   assign req_ready = state_ff == S_LOAD;
   assign rsp_valid = state_ff == S_EMIT;

   always_comb begin
      state_in = state_ff;
      pend_seed_in = pend_seed_ff;
      cmd = '0;
      unique case (state_ff)
         S_LOAD: begin
            cmd.load = req_valid;
            if (req_valid && req_last) state_in = S_INIT;
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_DEG;
         end
         S_DEG: begin
            if (sts.scan_end) begin
               state_in = S_CHECK;
               pend_seed_in = 1'b1;
            end else begin
               cmd.deg_step = 1'b1;
            end
         end
         S_CHECK: begin
            cmd.rewind = 1'b1;
            priority if (!sts.any_uncolored) state_in = S_EMIT;
            else if (pend_seed_ff || !sts.any_candidate) state_in = S_SEED;
            else state_in = S_SCORE;
         end
         S_SEED: begin
            if (sts.scan_end) begin
               cmd.seed_take = 1'b1;
               pend_seed_in = 1'b0;
               state_in = S_REFRESH;
            end else begin
               cmd.seed_step = 1'b1;
            end
         end
         S_REFRESH: begin
            if (sts.scan_end) state_in = S_CHECK;
            else cmd.refresh_step = 1'b1;
         end
         S_SCORE: begin
            if (sts.scan_end) begin
               cmd.pick_take = 1'b1;
               state_in = S_REFRESH;
            end else begin
               cmd.score_step = 1'b1;
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               cmd.emit_step = 1'b1;
               if (sts.emit_end) state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         pend_seed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_seed_ff <= pend_seed_in;
      end
   end

   `RLF_ASSERT_IMP(a_excl, clock, reset, rsp_valid, !req_ready)
   `RLF_ASSERT_NEXT(a_last, clock, reset, req_valid && req_ready && req_last, !req_ready)
   `RLF_ASSERT_NEXT(a_done, clock, reset, rsp_valid && rsp_ready && sts.emit_end, req_ready)
endmodule

### rtl/core/rlf_graph_coloring.sv
// Top level of the Recursive Largest First graph coloring block.
// channel | direction | transfer
// req     | in        | one adjacency row per cycle while req_ready is high
// rsp     | out       | one vertex and color per cycle while rsp_ready is high
// csr     | in        | vertex_count write, taken at once
// Rows load at one per cycle; the last row holds req_ready low until all results leave.
// Coloring n vertices: a setup step, the degree pass, then per vertex a check,
// a seed or score scan and a refresh scan, and at the end a final check; each
// scan reads one memory row a cycle.
// Results then leave one per cycle in vertex order; rsp_ready low holds them.
// Synchronous reset returns to loading and sets the vertex count to 64.
module rlf_graph_coloring #(
   parameter int MAX_VERTICES = rlf_pkg::MAX_VERTICES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rlf_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rlf_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [rlf_pkg::CNT_W-1:0] csr_wdata
);
   import rlf_pkg::*;
   cmd_type          cmd;
   sts_type          sts;
   logic [CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) count_ff <= CNT_W'(64);
      else if (csr_we) count_ff <= csr_wdata;
   end

   rlf_control u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_last(req_data.last_row), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .sts(sts), .cmd(cmd)
   );

   rlf_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .vertex_count(count_ff),
      .cmd(cmd), .sts(sts), .rsp_data(rsp_data)
   );
endmodule

### tb/testbench.sv
// Testbench for rlf_graph_coloring: directed and random graphs loaded by row, colorings checked.
`timescale 1ns / 1ps
module testbench;
   import rlf_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [6:0] csr_wdata;

   logic [63:0] stored_rows [64];
   logic [6:0]  vertex_limit;
   rsp_type     pending_colors [$];
   int          mismatches;
   int          rows_sent;
   bit          steady_ready;
   int          stall_left;

   rlf_graph_coloring dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

   function automatic void predict_coloring();
      int          n;
      logic [63:0] vmask, unc, reach, cand;
      logic [6:0]  color [64];
      logic [6:0]  degree [64];
      logic [6:0]  current;
      int          left, best, bestdeg, pickc, pickd, first, maxc, maxd, c, d;
      rsp_type     item;
      n = (vertex_limit < 1) ? 1 : (vertex_limit > 64) ? 64 : vertex_limit;
      vmask = (n >= 64) ? '1 : ((64'd1 << n) - 1);
      for (int i = 0; i < 64; i++) begin
         color[i] = '0;
         degree[i] = $countones(stored_rows[i] & vmask);
      end
      current = '0;
      left = n;
      while (left > 0) begin
         best = -1;
         bestdeg = 0;
         for (int i = 0; i < n; i++)
            if (color[i] == 0 && (best < 0 || degree[i] > bestdeg)) begin
               best = i;
               bestdeg = degree[i];
            end
         current++;
         color[best] = current;
         left--;
         forever begin
            unc = '0;
            reach = '0;
            for (int i = 0; i < n; i++) begin
               if (color[i] == 0) unc[i] = 1'b1;
               if (color[i] == current) reach |= stored_rows[i];
            end
            reach &= vmask;
            cand = unc & ~reach;
            if (cand == 0) break;
            reach &= unc;
            maxc = 0; maxd = 0; pickc = -1; pickd = -1; first = -1;
            for (int i = 0; i < n; i++) begin
               if (cand[i]) begin
                  if (first < 0) first = i;
                  c = $countones(stored_rows[i] & reach);
                  if (c > maxc) begin
                     maxc = c;
                     pickc = i;
                  end
                  d = $countones(stored_rows[i] & unc);
                  if (d > maxd) begin
                     maxd = d;
                     pickd = i;
                  end
               end
            end
            if (pickc < 0) pickc = (pickd >= 0) ? pickd : first;
            color[pickc] = current;
            left--;
         end
      end
      for (int i = 0; i < n; i++) begin
         item.vertex = i[5:0];
         item.color = color[i];
         item.last = (i == n - 1);
         pending_colors.push_back(item);
      end
   endfunction

   task automatic send_row(input logic [5:0] idx, input logic [63:0] bits, input bit fin);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) >= 70)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.row_index = idx;
      req_data.row_bits = bits;
      req_data.last_row = fin;
      do @(posedge clock); while (!req_ready);
      stored_rows[idx] = bits;
      rows_sent++;
      if (fin) predict_coloring();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain();
      while (pending_colors.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic set_vertex_count(input logic [6:0] value);
      drain();
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      vertex_limit = value;
   endtask

   task automatic send_graph(input int n, input int density, input bit symmetric);
      logic [63:0] rows [64];
      int          order [64];
      int          j, t;
      for (int i = 0; i < 64; i++) begin
         rows[i] = ($urandom_range(0, 1)) ? {$urandom, $urandom} : '0;
         for (int k = 0; k < n; k++) rows[i][k] = ($urandom_range(0, 99) < density);
         order[i] = i;
      end
      if (symmetric)
         for (int i = 0; i < n; i++)
            for (int k = 0; k < i; k++) rows[i][k] = rows[k][i];
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      if (n < 64 && $urandom_range(0, 3) == 0) begin
         j = $urandom_range(n, 63);
         send_row(j[5:0], rows[j], 1'b0);
      end
      for (int i = 0; i < n; i++) send_row(order[i][5:0], rows[order[i]], i == n - 1);
   endtask

   task automatic test_default_count();
      steady_ready = 1'b1;
      send_graph(64, 10, 1'b1);
      drain();
      steady_ready = 1'b0;
   endtask

   task automatic test_single_vertex();
      set_vertex_count(7'd0);
      send_row(6'd0, '1, 1'b1);
   endtask

   task automatic test_two_vertices();
      set_vertex_count(7'd2);
      send_row(6'd0, 64'h3, 1'b0);
      send_row(6'd1, 64'h3, 1'b1);
      send_row(6'd0, 64'h0, 1'b1);
      send_row(6'd1, 64'h0, 1'b1);
   endtask

   task automatic test_asymmetric();
      set_vertex_count(7'd3);
      send_row(6'd0, 64'h2, 1'b0);
      send_row(6'd1, 64'h0, 1'b0);
      send_row(6'd2, 64'hFFFF_FFFF_FFFF_FFF8, 1'b1);
      send_row(6'd63, '1, 1'b1);
   endtask

   task automatic test_count_clamp();
      set_vertex_count(7'd127);
      send_row(6'd5, 64'h0, 1'b1);
      set_vertex_count(7'd64);
      send_row(6'd40, '1, 1'b1);
   endtask

   task automatic test_random_graphs();
      int n;
      while (rows_sent < 170) begin
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
         set_vertex_count(n[6:0]);
         send_graph(n, $urandom_range(0, 100), $urandom_range(0, 4) != 0);
         steady_ready = ($urandom_range(0, 4) == 0);
      end
      drain();
   endtask

   always @(negedge clock) begin
      if (steady_ready) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 15) begin
         rsp_ready <= 1'b0;
         stall_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_colors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer: %p", rsp_data);
         end else begin
            want = pending_colors.pop_front();
            if (rsp_data.vertex !== want.vertex || rsp_data.color !== want.color ||
                rsp_data.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", want, rsp_data);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      vertex_limit = 7'd64;
      mismatches = 0;
      rows_sent = 0;
      steady_ready = 1'b0;
      stall_left = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      test_default_count();
      test_single_vertex();
      test_two_vertices();
      test_asymmetric();
      test_count_clamp();
      test_random_graphs();
      if (mismatches == 0 && pending_colors.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/rlf_pkg.sv
rtl/core/rlf_ram.sv
rtl/core/rlf_datapath.sv
rtl/core/rlf_control.sv
rtl/core/rlf_graph_coloring.sv
tb/testbench.sv
